// ===== design/assert_macros.svh =====
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define FRA_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define FRA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/fra_pkg.sv =====
package fra_pkg;

   localparam int WINDOWS_DEFAULT = 4;
   localparam logic [31:0] RING_SIZE_RESET = 32'd65536;

   typedef struct packed {
      logic [31:0] req_size;
      logic [4:0]  align_log2;
      logic [47:0] current_frame;
      logic [47:0] completed_frame;
   } fra_req_type;

   typedef struct packed {
      logic        granted;
      logic [31:0] offset;
   } fra_rsp_type;

   typedef struct packed {
      logic [47:0] frame;
      logic [31:0] start;
      logic [31:0] stop;
   } fra_window_type;

   typedef struct packed {
      logic shift;
      logic load;
   } fra_cell_ctrl_type;

   typedef enum logic [2:0] {
      FRA_IDLE,
      FRA_RETIRE,
      FRA_FIT,
      FRA_CHECK,
      FRA_RESP
   } fra_state_type;

endpackage

// ===== design/fra_cell.sv =====
module fra_cell
   import fra_pkg::*;
(
   input  logic              clock,
   input  fra_cell_ctrl_type ctrl,
   input  fra_window_type    shift_data,
   input  fra_window_type    load_data,
   output fra_window_type    window
);

   fra_window_type window_ff;
   fra_window_type window_in;

   always_comb begin
      window_in = window_ff;
      if (ctrl.load) begin
         window_in = load_data;
      end else if (ctrl.shift) begin
         window_in = shift_data;
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
   end

   assign window = window_ff;

endmodule

// ===== design/frame_ring_allocator_unit.sv =====
// channel   direction  handshake              payload
// req       in         req_valid / req_stall  fra_req_type
// rsp       out        rsp_valid / rsp_stall  fra_rsp_type
// csr       in         csr_write_enable       ring size, 32 bits
// a request goes from acceptance through RETIRE, FIT and CHECK to RESP, which
// registers its response; RETIRE shifts out 0 to WINDOWS windows, one per cycle
// a size that is zero or above the ring goes straight to RESP and is refused
// a ring size write empties the window queue on the edge that loads the new size
// reset is synchronous; after it the queue is empty and the ring size is 65536
// a stalled response holds the block in its last step; the next request waits
module frame_ring_allocator_unit
   import fra_pkg::*;
#(
   parameter int WINDOWS = WINDOWS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  fra_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output fra_rsp_type rsp_data,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);

   `include "assert_macros.svh"

   localparam int CNT_W = $clog2(WINDOWS + 1);
   localparam int IDX_W = $clog2(WINDOWS);

   fra_state_type  state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0]    ring_ff, ring_in;
   logic [31:0]    size_ff, size_in;
   logic [47:0]    cur_ff, cur_in;
   logic [47:0]    done_ff, done_in;
   logic [32:0]    start_ff, start_in;
   logic [31:0]    end_ff, end_in;
   fra_rsp_type    res_ff, res_in;
   fra_rsp_type    rsp_ff, rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;

   fra_window_type    window [WINDOWS];
   fra_cell_ctrl_type ctrl [WINDOWS];
   fra_window_type    load_data;
   logic              shift;
   logic              do_extend;
   logic              do_push;

   logic [IDX_W-1:0] newest_idx;
   logic [IDX_W-1:0] push_idx;
   fra_window_type   newest;
   logic [32:0]      align_mask;
   logic [33:0]      fit_sum;
   logic [31:0]      lo;
   logic [31:0]      hi;
   logic [31:0]      start32;
   logic             hit;
   logic             accept;

   assign accept     = req_valid && !req_stall;
   assign newest_idx = IDX_W'(count_ff - CNT_W'(1));
   assign push_idx   = count_ff[IDX_W-1:0];
   assign newest     = window[newest_idx];
   assign align_mask = (33'd1 << req_data.align_log2) - 33'd1;
   assign fit_sum    = {1'b0, start_ff} + {2'b0, size_ff};
   assign lo         = window[0].start;
   assign hi         = newest.stop;
   assign start32    = start_ff[31:0];

   always_comb begin
      if (count_ff == '0) begin
         hit = 1'b0;
      end else if (hi >= lo) begin
         hit = (end_ff > lo) && (start32 < hi);
      end else begin
         hit = (end_ff > lo) || (start32 < hi);
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ring_in      = ring_ff;
      size_in      = size_ff;
      cur_in       = cur_ff;
      done_in      = done_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      shift        = 1'b0;
      do_extend    = 1'b0;
      do_push      = 1'b0;
      req_stall    = (state_ff != FRA_IDLE);

      case (state_ff)
         FRA_IDLE: begin
            if (accept) begin
               size_in = req_data.req_size;
               cur_in  = req_data.current_frame;
               done_in = req_data.completed_frame;
               if (count_ff == '0) begin
                  start_in = '0;
               end else begin
                  start_in = ({1'b0, newest.stop} + align_mask) & ~align_mask;
               end
               if (req_data.req_size == '0 || req_data.req_size > ring_ff) begin
                  res_in   = '0;
                  state_in = FRA_RESP;
               end else begin
                  state_in = FRA_RETIRE;
               end
            end
         end
         FRA_RETIRE: begin
            if (count_ff != '0 && window[0].frame <= done_ff) begin
               shift    = 1'b1;
               count_in = count_ff - CNT_W'(1);
            end else begin
               state_in = FRA_FIT;
            end
         end
         FRA_FIT: begin
            if (fit_sum > {2'b0, ring_ff}) begin
               start_in = '0;
               end_in   = size_ff;
            end else begin
               end_in = fit_sum[31:0];
            end
            state_in = FRA_CHECK;
         end
         FRA_CHECK: begin
            res_in = '0;
            if (!hit) begin
               if (count_ff != '0 && newest.frame == cur_ff) begin
                  do_extend = 1'b1;
               end else if (count_ff < CNT_W'(WINDOWS)) begin
                  do_push  = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            if (do_extend || do_push) begin
               res_in.granted = 1'b1;
               res_in.offset  = start32;
            end
            state_in = FRA_RESP;
         end
         FRA_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = FRA_IDLE;
            end
         end
         default: begin
            state_in = FRA_IDLE;
         end
      endcase

      if (csr_write_enable) begin
         ring_in  = csr_write_data;
         count_in = '0;
      end
   end

   always_comb begin
      if (do_extend) begin
         load_data      = newest;
         load_data.stop = end_ff;
      end else begin
         load_data.frame = cur_ff;
         load_data.start = start32;
         load_data.stop  = end_ff;
      end
   end

   for (genvar i = 0; i < WINDOWS; i++) begin : g_cell
      fra_window_type next_data;

      if (i == WINDOWS - 1) begin : g_last
         assign next_data = window[i];
      end else begin : g_mid
         assign next_data = window[i+1];
      end

      assign ctrl[i].shift = shift;
      assign ctrl[i].load  = (do_extend && newest_idx == IDX_W'(i)) ||
                             (do_push && push_idx == IDX_W'(i));

      fra_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl[i]),
         .shift_data (next_data),
         .load_data  (load_data),
         .window     (window[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FRA_IDLE;
         count_ff     <= '0;
         ring_ff      <= RING_SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ring_ff      <= ring_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      size_ff  <= size_in;
      cur_ff   <= cur_in;
      done_ff  <= done_in;
      start_ff <= start_in;
      end_ff   <= end_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `FRA_ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(WINDOWS), "window count overflow")
   `FRA_ASSERT_ALWAYS(a_refused_offset, !rsp_valid_ff || rsp_ff.granted || rsp_ff.offset == '0,
      "refused response with nonzero offset")
   `FRA_ASSERT_NEXT(a_accept_busy, accept, req_stall, "request taken while busy")
   `FRA_ASSERT_NEXT(a_retire_step, shift && !csr_write_enable,
      count_ff == $past(count_ff) - CNT_W'(1), "retire did not drop one window")

endmodule
